@@ hdl/aat_pkg.sv @@
// shared constants, types and register codes for the aging address table
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

  // table depth default
  localparam int DEPTH_DEFAULT = 32;

  // field widths
  localparam int ADDR_W     = 48;
  localparam int STR_W      = 8;
  localparam int PROTO_W    = 2;
  localparam int TIME_W     = 32;
  localparam int LIMIT_W    = 6;
  localparam int SLOT_W     = 5;
  localparam int OCC_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd1;

  // register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 6'd32;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd30000;

  // sighting and sweep item kinds
  localparam logic KIND_SIGHTING = 1'b0;
  localparam logic KIND_SWEEP    = 1'b1;

  // one stored entry
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [STR_W-1:0]   strength;
    logic [TIME_W-1:0]  seen;
    logic [PROTO_W-1:0] protocol;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic              found;
    logic              inserted;
    logic              full_res;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occupancy;
    logic [OCC_W-1:0]  expired;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/aat_in_if.sv @@
// input item channel
`timescale 1ns / 1ps
`default_nettype none

interface aat_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [aat_pkg::ADDR_W-1:0]         address;
  logic signed [aat_pkg::STR_W-1:0]   strength;
  logic [aat_pkg::PROTO_W-1:0]        protocol;
  logic [aat_pkg::TIME_W-1:0]         now_ms;

  modport source (output valid, kind, address, strength, protocol, now_ms, input ready);
  modport sink   (input valid, kind, address, strength, protocol, now_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/aat_out_if.sv @@
// result channel
`timescale 1ns / 1ps
`default_nettype none

interface aat_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic                        inserted;
  logic                        full_res;
  logic [aat_pkg::SLOT_W-1:0]  slot;
  logic [aat_pkg::OCC_W-1:0]   occupancy;
  logic [aat_pkg::OCC_W-1:0]   expired;

  modport source (output valid, found, inserted, full_res, slot, occupancy, expired,
                  input ready);
  modport sink   (input valid, found, inserted, full_res, slot, occupancy, expired,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/aat_cfg_if.sv @@
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface aat_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aat_pkg::CFG_IDX_W-1:0]  index;
  logic [aat_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/aat_ctrl.sv @@
// controller state machine of the aging address table
`timescale 1ns / 1ps
`default_nettype none

module aat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire aat_pkg::sts_t sts,
  output aat_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_HOLD;
        end else if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

@@ hdl/aat_dpath.sv @@
// datapath of the aging address table: entry memory, scan, compaction, output register
`timescale 1ns / 1ps
`default_nettype none

module aat_dpath #(
  parameter int DEPTH = aat_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire aat_pkg::cmd_t                       cmd,
  output aat_pkg::sts_t                            sts,
  input  wire logic                                in_kind,
  input  wire logic [aat_pkg::ADDR_W-1:0]          in_address,
  input  wire logic signed [aat_pkg::STR_W-1:0]    in_strength,
  input  wire logic [aat_pkg::PROTO_W-1:0]         in_protocol,
  input  wire logic [aat_pkg::TIME_W-1:0]          in_now_ms,
  input  wire logic                                cfg_we,
  input  wire logic [aat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aat_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output aat_pkg::res_t                            out_res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > aat_pkg::LIMIT_W) ? CW : aat_pkg::LIMIT_W;

  // entry memory
  aat_pkg::entry_t mem [DEPTH];

  // item registers
  logic                          kind_r;
  logic [aat_pkg::ADDR_W-1:0]    addr_r;
  logic [aat_pkg::STR_W-1:0]     str_r;
  logic [aat_pkg::PROTO_W-1:0]   proto_r;
  logic [aat_pkg::TIME_W-1:0]    now_r;

  // table and configuration state
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [aat_pkg::LIMIT_W-1:0]   limit_r;
  logic [aat_pkg::TIME_W-1:0]    timeout_r;

  // scan pipeline
  logic [CW-1:0]                 rd_idx_r;
  logic [CW-1:0]                 chk_idx_r;
  logic                          rvalid_r;
  aat_pkg::entry_t               rdata_r;
  logic [CW-1:0]                 keep_r;
  logic [CW-1:0]                 removed_r;

  // result staging and output register
  aat_pkg::res_t                 res_r;
  aat_pkg::res_t                 out_r;
  logic                          out_valid_r, out_valid_nxt;

  logic                          rd_en;
  logic                          match;
  logic                          stale;
  logic                          room;
  logic [aat_pkg::TIME_W-1:0]    age;
  logic                          mem_we;
  logic [IW-1:0]                 mem_wa;
  aat_pkg::entry_t               mem_wd;
  aat_pkg::entry_t               new_entry;

  // compare and age of the entry just read
  always_comb begin
    rd_en     = cmd.scan && (rd_idx_r < cnt_r);
    match     = rvalid_r && (kind_r == aat_pkg::KIND_SIGHTING) && (rdata_r.address == addr_r);
    age       = now_r - rdata_r.seen;
    stale     = age > timeout_r;
    room      = (XW'(cnt_r) < XW'(limit_r)) && (cnt_r != CW'(DEPTH));
    new_entry = '{address: addr_r, strength: str_r, seen: now_r, protocol: proto_r};
  end

  // status to controller
  always_comb begin
    sts.hit       = match;
    sts.scan_done = !rvalid_r && (rd_idx_r == cnt_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // memory write port: refresh on hit, compaction on sweep, append on miss while there is room
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rdata_r;
    if (cmd.scan && match) begin
      mem_we = 1'b1;
      mem_wa = chk_idx_r[IW-1:0];
      mem_wd = '{address: rdata_r.address, strength: str_r, seen: now_r,
                 protocol: rdata_r.protocol};
    end else if (cmd.scan && rvalid_r && (kind_r == aat_pkg::KIND_SWEEP) && !stale) begin
      mem_we = 1'b1;
      mem_wa = keep_r[IW-1:0];
      mem_wd = rdata_r;
    end else if (cmd.finish && (kind_r == aat_pkg::KIND_SIGHTING) && room) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[IW-1:0];
      mem_wd = new_entry;
    end
  end

  // entry count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.finish) begin
      if (kind_r == aat_pkg::KIND_SWEEP) begin
        cnt_nxt = keep_r;
      end else if (room) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  // output beat handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      limit_r     <= aat_pkg::LIMIT_RESET;
      timeout_r   <= aat_pkg::TIMEOUT_RESET;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rvalid_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          aat_pkg::REG_ENTRY_LIMIT: limit_r   <= cfg_data[aat_pkg::LIMIT_W-1:0];
          aat_pkg::REG_TIMEOUT_MS:  timeout_r <= cfg_data[aat_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item capture, scan counters, memory and results
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r    <= in_kind;
      addr_r    <= in_address;
      str_r     <= in_strength;
      proto_r   <= in_protocol;
      now_r     <= in_now_ms;
      rd_idx_r  <= '0;
      keep_r    <= '0;
      removed_r <= '0;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_idx_r[IW-1:0]];
      chk_idx_r <= rd_idx_r;
      rd_idx_r  <= rd_idx_r + CW'(1);
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    // sweep counters
    if (cmd.scan && rvalid_r && (kind_r == aat_pkg::KIND_SWEEP)) begin
      if (stale) begin
        removed_r <= removed_r + CW'(1);
      end else begin
        keep_r <= keep_r + CW'(1);
      end
    end
    // result of a hit
    if (cmd.scan && match) begin
      res_r <= '{found: 1'b1, inserted: 1'b0, full_res: 1'b0,
                 slot: aat_pkg::SLOT_W'(chk_idx_r),
                 occupancy: aat_pkg::OCC_W'(cnt_r), expired: '0};
    end
    // result at the end of a scan
    if (cmd.finish) begin
      priority if (kind_r == aat_pkg::KIND_SWEEP) begin
        res_r <= '{found: 1'b0, inserted: 1'b0, full_res: 1'b0, slot: '0,
                   occupancy: aat_pkg::OCC_W'(keep_r),
                   expired: aat_pkg::OCC_W'(removed_r)};
      end else if (room) begin
        res_r <= '{found: 1'b0, inserted: 1'b1, full_res: 1'b0,
                   slot: aat_pkg::SLOT_W'(cnt_r),
                   occupancy: aat_pkg::OCC_W'(cnt_r + CW'(1)), expired: '0};
      end else begin
        res_r <= '{found: 1'b0, inserted: 1'b0, full_res: 1'b1, slot: '0,
                   occupancy: aat_pkg::OCC_W'(cnt_r), expired: '0};
      end
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

@@ hdl/aging_address_table_unit.sv @@
// top level of the aging address table
//
// Tracks up to DEPTH transmitters keyed by a 48-bit address.
// in_ch carries one item per beat: a sighting (kind 0) or an expiry sweep
// (kind 1). out_ch returns exactly one result beat per item. cfg_ch writes
// entry_limit (index 0) and timeout_ms (index 1); it is always ready and
// must only be used while no item is in flight.
// Timing: entries are held in a single-port-read memory and scanned one
// entry per cycle. A sighting that hits entry i ends its scan there; a
// miss or a sweep over n entries scans all of them. in_ch is ready again
// once the result has been moved into the output register and takes no
// new item before that; the scan through the memory read port sets how
// long each item takes.
// Reset: table empty, entry_limit 32, timeout_ms 30000, no result pending;
// entry contents are not cleared and need no clearing pass.
// Stall: a held result stays on out_ch; one further item is worked on and
// then waits until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module aging_address_table_unit #(
  parameter int DEPTH = aat_pkg::DEPTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst_n,
  aat_in_if.sink   in_ch,
  aat_out_if.source out_ch,
  aat_cfg_if.sink  cfg_ch
);

  aat_pkg::cmd_t cmd;
  aat_pkg::sts_t sts;
  aat_pkg::res_t res;
  logic          in_ready;
  logic          out_valid;

  // controller
  aat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  aat_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_ch.kind),
    .in_address  (in_ch.address),
    .in_strength (in_ch.strength),
    .in_protocol (in_ch.protocol),
    .in_now_ms   (in_ch.now_ms),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_res     (res)
  );

  // channel hookup
  assign in_ch.ready      = in_ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid;
  assign out_ch.found     = res.found;
  assign out_ch.inserted  = res.inserted;
  assign out_ch.full_res  = res.full_res;
  assign out_ch.slot      = res.slot;
  assign out_ch.occupancy = res.occupancy;
  assign out_ch.expired   = res.expired;

endmodule

`default_nettype wire

@@ hdl/aat_checker.sv @@
// port-level checks of the aging address table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module aat_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       found,
  input wire logic                       inserted,
  input wire logic                       full_res,
  input wire logic [aat_pkg::SLOT_W-1:0] slot,
  input wire logic [aat_pkg::OCC_W-1:0]  occupancy,
  input wire logic [aat_pkg::OCC_W-1:0]  expired
);

  // at most one sighting outcome per result beat
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({found, inserted, full_res}) <= 1))
    else $error("more than one sighting outcome in a result beat");

  // a sweep that removed entries reports no sighting outcome
  a_sweep_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (expired != '0)) |-> (!found && !inserted && !full_res))
    else $error("sweep result carries a sighting outcome");

  // a dropped sighting reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && full_res) |-> (slot == '0))
    else $error("full result with nonzero slot");

  // one item at a time: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(slot) && $stable(occupancy)))
    else $error("result beat changed while stalled");

endmodule

bind aging_address_table_unit aat_checker u_aat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .found     (out_ch.found),
  .inserted  (out_ch.inserted),
  .full_res  (out_ch.full_res),
  .slot      (out_ch.slot),
  .occupancy (out_ch.occupancy),
  .expired   (out_ch.expired)
);

`default_nettype wire
